>>> hdl/dws_pkg.sv
package dws_pkg;

   // Ring geometry
   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   // Field widths
   localparam int DATA_W = 32;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;
   localparam int POS_W  = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd5;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISSING = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] out_value;
      logic [POS_W-1:0]         position;
      logic                     last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK
   } state_type;

   // Element memory access, one write and one read port
   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
      logic [IDX_W-1:0]         rd_addr;
   } store_ctl_type;

endpackage

>>> hdl/dws_store.sv
module dws_store (
   input  logic                              clock,
   input  dws_pkg::store_ctl_type            ctl,
   output logic signed [dws_pkg::DATA_W-1:0] rd_data
);

   logic signed [dws_pkg::DATA_W-1:0] mem [dws_pkg::DEPTH];
   logic signed [dws_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/deque_with_search.sv
// Bounded double-ended queue of signed 32-bit values held in a ring of DEPTH
// entries, with push/pop at either end, a front-to-back listing and a value
// search. One command is in flight at a time: req_ready is high only while
// the sequencer is idle. A push, or any command on an empty store, ends in
// the execute state; a pop goes on to the walk state, since it waits for the
// memory read. A list walks the ring one entry per cycle while the result
// side does not stall, through the single read port of the element memory,
// and issues one result transaction per stored element; a search compares
// one entry per cycle against the key in the same walk and stops at the
// first match or after the last stored element. Every command yields
// exactly one result transaction except list on a non-empty store, which
// yields one per element with last set on the final one; command codes six
// and seven are dropped without a result. The result register lets the next
// request be accepted while the previous result is still waiting on
// rsp_ready.
module deque_with_search (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dws_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dws_pkg::rsp_type rsp_data
);

   localparam int IDX_W = dws_pkg::IDX_W;
   localparam int CNT_W = dws_pkg::CNT_W;
   localparam int SUM_W = dws_pkg::SUM_W;

   // sequencer
   dws_pkg::state_type state_ff, state_in;

   // latched command
   logic [dws_pkg::CMD_W-1:0]         cmd_ff, cmd_in;
   logic signed [dws_pkg::DATA_W-1:0] value_ff, value_in;

   // ring pointers
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] occ_ff, occ_in;

   // walk position: count from front and ring slot
   logic [IDX_W-1:0] walk_cnt_ff, walk_cnt_in;
   logic [IDX_W-1:0] walk_slot_ff, walk_slot_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   dws_pkg::rsp_type rsp_ff, rsp_in;

   // memory
   dws_pkg::store_ctl_type            store_ctl;
   logic signed [dws_pkg::DATA_W-1:0] rd_data;

   // shared helpers
   logic             slot_free;
   logic             cmd_known;
   logic             is_push;
   logic             full;
   logic             empty;
   logic [CNT_W-1:0] add_b;
   logic [SUM_W-1:0] end_sum;
   logic [IDX_W-1:0] end_slot;
   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] front_inc;
   logic [IDX_W-1:0] walk_slot_next;
   logic             walk_last;
   logic             match;
   logic [dws_pkg::POS_W-1:0] walk_pos;

   dws_store u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == dws_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // result register can take a new transaction this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign cmd_known = (cmd_ff == dws_pkg::CMD_PUSH_FRONT) ||
                      (cmd_ff == dws_pkg::CMD_PUSH_BACK)  ||
                      (cmd_ff == dws_pkg::CMD_POP_FRONT)  ||
                      (cmd_ff == dws_pkg::CMD_POP_BACK)   ||
                      (cmd_ff == dws_pkg::CMD_LIST)       ||
                      (cmd_ff == dws_pkg::CMD_SEARCH);
   assign is_push   = (cmd_ff == dws_pkg::CMD_PUSH_FRONT) ||
                      (cmd_ff == dws_pkg::CMD_PUSH_BACK);
   assign full      = (occ_ff == CNT_W'(dws_pkg::DEPTH));
   assign empty     = (occ_ff == '0);

   // back end slot: front + occ for push back, front + occ - 1 for pop back,
   // wrapped with one compare and subtract (sum stays below 2*DEPTH)
   assign add_b    = (cmd_ff == dws_pkg::CMD_PUSH_BACK) ? occ_ff : occ_ff - CNT_W'(1);
   assign end_sum  = SUM_W'(front_ff) + SUM_W'(add_b);
   assign end_slot = (end_sum >= SUM_W'(dws_pkg::DEPTH)) ?
                     IDX_W'(end_sum - SUM_W'(dws_pkg::DEPTH)) : IDX_W'(end_sum);

   assign front_dec = (front_ff == '0) ? IDX_W'(dws_pkg::DEPTH - 1) : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == IDX_W'(dws_pkg::DEPTH - 1)) ? '0 : front_ff + IDX_W'(1);
   assign walk_slot_next = (walk_slot_ff == IDX_W'(dws_pkg::DEPTH - 1)) ? '0 :
                           walk_slot_ff + IDX_W'(1);

   assign walk_last = ((CNT_W'(walk_cnt_ff) + CNT_W'(1)) == occ_ff);
   assign match     = (rd_data == value_ff);
   assign walk_pos  = dws_pkg::POS_W'(walk_cnt_ff) + dws_pkg::POS_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dws_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dws_pkg::ST_EXEC;
            end
         end
         dws_pkg::ST_EXEC: begin
            if (!cmd_known) begin
               state_in = dws_pkg::ST_IDLE;
            end else if (is_push || empty) begin
               if (slot_free) begin
                  state_in = dws_pkg::ST_IDLE;
               end
            end else begin
               state_in = dws_pkg::ST_WALK;
            end
         end
         dws_pkg::ST_WALK: begin
            unique case (cmd_ff)
               dws_pkg::CMD_LIST: begin
                  if (slot_free && walk_last) begin
                     state_in = dws_pkg::ST_IDLE;
                  end
               end
               dws_pkg::CMD_SEARCH: begin
                  if (slot_free && (match || walk_last)) begin
                     state_in = dws_pkg::ST_IDLE;
                  end
               end
               default: begin
                  // pops
                  if (slot_free) begin
                     state_in = dws_pkg::ST_IDLE;
                  end
               end
            endcase
         end
         default: state_in = dws_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      front_in     = front_ff;
      occ_in       = occ_ff;
      walk_cnt_in  = walk_cnt_ff;
      walk_slot_in = walk_slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      store_ctl    = '0;

      unique case (state_ff)
         dws_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               value_in = req_data.item_value;
            end
         end
         dws_pkg::ST_EXEC: begin
            if (cmd_known) begin
               if (is_push) begin
                  if (slot_free) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = full ? dws_pkg::STAT_FULL : dws_pkg::STAT_OK;
                     rsp_in.out_value = '0;
                     rsp_in.position  = '0;
                     rsp_in.last      = 1'b1;
                     if (!full) begin
                        store_ctl.wr_en   = 1'b1;
                        store_ctl.wr_data = value_ff;
                        occ_in            = occ_ff + CNT_W'(1);
                        if (cmd_ff == dws_pkg::CMD_PUSH_FRONT) begin
                           front_in          = front_dec;
                           store_ctl.wr_addr = front_dec;
                        end else begin
                           store_ctl.wr_addr = end_slot;
                        end
                     end
                  end
               end else if (empty) begin
                  if (slot_free) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = dws_pkg::STAT_EMPTY;
                     rsp_in.out_value = '0;
                     rsp_in.position  = '0;
                     rsp_in.last      = 1'b1;
                  end
               end else begin
                  // first read of the walk (or the single pop read)
                  store_ctl.rd_en   = 1'b1;
                  store_ctl.rd_addr = (cmd_ff == dws_pkg::CMD_POP_BACK) ? end_slot : front_ff;
                  walk_cnt_in       = '0;
                  walk_slot_in      = front_ff;
               end
            end
         end
         dws_pkg::ST_WALK: begin
            unique case (cmd_ff)
               dws_pkg::CMD_POP_FRONT, dws_pkg::CMD_POP_BACK: begin
                  if (slot_free) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = dws_pkg::STAT_OK;
                     rsp_in.out_value = rd_data;
                     rsp_in.position  = '0;
                     rsp_in.last      = 1'b1;
                     occ_in           = occ_ff - CNT_W'(1);
                     if (cmd_ff == dws_pkg::CMD_POP_FRONT) begin
                        front_in = front_inc;
                     end
                  end
               end
               dws_pkg::CMD_LIST: begin
                  if (slot_free) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = dws_pkg::STAT_OK;
                     rsp_in.out_value = rd_data;
                     rsp_in.position  = walk_pos;
                     rsp_in.last      = walk_last;
                     if (!walk_last) begin
                        store_ctl.rd_en   = 1'b1;
                        store_ctl.rd_addr = walk_slot_next;
                        walk_slot_in      = walk_slot_next;
                        walk_cnt_in       = walk_cnt_ff + IDX_W'(1);
                     end
                  end
               end
               default: begin
                  // search: one compare per cycle
                  if (match) begin
                     if (slot_free) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.status    = dws_pkg::STAT_OK;
                        rsp_in.out_value = value_ff;
                        rsp_in.position  = walk_pos;
                        rsp_in.last      = 1'b1;
                     end
                  end else if (walk_last) begin
                     if (slot_free) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.status    = dws_pkg::STAT_MISSING;
                        rsp_in.out_value = '0;
                        rsp_in.position  = '0;
                        rsp_in.last      = 1'b1;
                     end
                  end else begin
                     store_ctl.rd_en   = 1'b1;
                     store_ctl.rd_addr = walk_slot_next;
                     walk_slot_in      = walk_slot_next;
                     walk_cnt_in       = walk_cnt_ff + IDX_W'(1);
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dws_pkg::ST_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      value_ff     <= value_in;
      walk_cnt_ff  <= walk_cnt_in;
      walk_slot_ff <= walk_slot_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(dws_pkg::DEPTH))
      else $error("occupancy above ring depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= IDX_W'(dws_pkg::DEPTH - 1))
      else $error("front index outside ring");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dws_pkg::ST_WALK) |-> (CNT_W'(walk_cnt_ff) < occ_ff))
      else $error("walk beyond stored elements");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((occ_ff == $past(occ_ff)) ||
                (occ_ff == $past(occ_ff) + CNT_W'(1)) ||
                (occ_ff == $past(occ_ff) - CNT_W'(1))))
      else $error("occupancy moved by more than one");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a command is in flight");
`endif

endmodule
